@@ rtl/core/b64d_pkg.sv @@
package b64d_pkg;

   localparam int QDEPTH = 8;
   localparam int QPTR_W = 3;
   localparam int QCNT_W = 4;
   localparam int MAX_RES = 3;

   typedef struct packed {
      logic [1:0]       count;
      logic [2:0][7:0]  data;
      logic             byte_valid;
      logic             done;
   } b64d_result_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       message_done;
   } b64d_entry_type;

endpackage

@@ rtl/core/base64_stream_decoder.sv @@
// channel   dir  tdata            tuser        tlast
// req_      in   symbol[7:0]      -            end_of_message
// rsp_      out  data_byte[7:0]   byte_valid   message_done
//
// One request is taken per cycle; its up to three results go to an
// eight-entry result queue and leave one per cycle while rsp_tready is high.
// req_tready drops while fewer than three queue entries are free.
// Four symbols yield three bytes, so a steady stream runs at one request per cycle.
// Synchronous active-high reset empties the queue and clears decoder state.
module base64_stream_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] symbol
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] data_byte
   output logic       rsp_tuser,    // [0] byte_valid
   output logic       rsp_tlast
);

   localparam int QPTR_W = b64d_pkg::QPTR_W;
   localparam int QCNT_W = b64d_pkg::QCNT_W;

   b64d_pkg::b64d_result_type res;
   b64d_pkg::b64d_entry_type  queue_ff [b64d_pkg::QDEPTH];

   logic [QPTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              push, pop;
   logic [QPTR_W-1:0] n_ext;

   assign push  = req_tvalid && req_tready;
   assign pop   = rsp_tvalid && rsp_tready;
   assign n_ext = QPTR_W'(res.count);

   assign req_tready = (cnt_ff <= QCNT_W'(b64d_pkg::QDEPTH - b64d_pkg::MAX_RES));
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = queue_ff[head_ff].data_byte;
   assign rsp_tuser  = queue_ff[head_ff].byte_valid;
   assign rsp_tlast  = queue_ff[head_ff].message_done;

   b64d_core u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (push),
      .symbol         (req_tdata),
      .end_of_message (req_tlast),
      .result         (res)
   );

   always_comb begin
      head_in = head_ff + (pop ? QPTR_W'(1) : '0);
      tail_in = tail_ff + (push ? n_ext : '0);
      cnt_in  = cnt_ff + (push ? QCNT_W'(res.count) : '0) - (pop ? QCNT_W'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < b64d_pkg::QDEPTH; i++) begin
         logic [QPTR_W-1:0] offset;
         offset = QPTR_W'(i) - tail_ff;
         if (push && offset < n_ext) begin
            queue_ff[i].data_byte    <= res.data[offset[1:0]];
            queue_ff[i].byte_valid   <= res.byte_valid;
            queue_ff[i].message_done <= res.done && (offset == n_ext - QPTR_W'(1));
         end
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(b64d_pkg::QDEPTH))
      else $error("result queue overflow");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && !(push && res.count != 2'd0)) |=> cnt_ff == $past(cnt_ff) - QCNT_W'(1))
      else $error("queue count not decremented on pop");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != QCNT_W'(b64d_pkg::QDEPTH)) |->
         ((tail_ff - head_ff) == cnt_ff[QPTR_W-1:0]))
      else $error("queue pointers disagree with count");
`endif

endmodule

@@ rtl/core/b64d_core.sv @@
module b64d_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               symbol,
   input  logic                     end_of_message,
   output b64d_pkg::b64d_result_type result
);

   localparam logic [1:0] CLS_SYM  = 2'd0;
   localparam logic [1:0] CLS_SKIP = 2'd1;
   localparam logic [1:0] CLS_BAD  = 2'd2;

   logic [17:0] group_ff, group_in;
   logic [1:0]  count_ff, count_in;
   logic        halted_ff, halted_in;

   logic [1:0]  cls;
   logic [5:0]  value;
   logic [7:0]  sym_a, sym_l, sym_d;
   logic [23:0] word;
   logic [17:0] fl_group;
   logic [1:0]  fl_count;
   logic        do_flush;
   logic [1:0]  n;
   logic [2:0][7:0] bytes;

   assign sym_a = symbol - 8'h41;
   assign sym_l = symbol - 8'h47;   // 'a' maps to 26
   assign sym_d = symbol + 8'h04;   // '0' maps to 52

   always_comb begin
      cls   = CLS_BAD;
      value = 6'd0;
      if (symbol >= 8'h41 && symbol <= 8'h5a) begin
         cls   = CLS_SYM;
         value = sym_a[5:0];
      end else if (symbol >= 8'h61 && symbol <= 8'h7a) begin
         cls   = CLS_SYM;
         value = sym_l[5:0];
      end else if (symbol >= 8'h30 && symbol <= 8'h39) begin
         cls   = CLS_SYM;
         value = sym_d[5:0];
      end else if (symbol == 8'h2b) begin
         cls   = CLS_SYM;
         value = 6'd62;
      end else if (symbol == 8'h2f) begin
         cls   = CLS_SYM;
         value = 6'd63;
      end else if (symbol == 8'h0a || symbol == 8'h0d) begin
         cls   = CLS_SKIP;
      end
   end

   assign word = {group_ff, value};

   always_comb begin
      group_in  = group_ff;
      count_in  = count_ff;
      halted_in = halted_ff;
      n         = 2'd0;
      bytes     = '0;
      do_flush  = 1'b0;
      fl_group  = group_ff;
      fl_count  = count_ff;
      if (!halted_ff) begin
         if (cls == CLS_SYM) begin
            if (count_ff == 2'd3) begin
               n        = 2'd3;
               bytes[0] = word[23:16];
               bytes[1] = word[15:8];
               bytes[2] = word[7:0];
               group_in = '0;
               count_in = 2'd0;
            end else begin
               group_in = {group_ff[11:0], value};
               count_in = count_ff + 2'd1;
            end
         end else if (cls == CLS_BAD) begin
            do_flush  = 1'b1;
            halted_in = 1'b1;
         end
         if (cls != CLS_BAD && end_of_message) begin
            do_flush = 1'b1;
            fl_group = group_in;
            fl_count = count_in;
         end
         if (do_flush) begin
            if (fl_count == 2'd2) begin
               n        = 2'd1;
               bytes[0] = fl_group[11:4];
            end else if (fl_count == 2'd3) begin
               n        = 2'd2;
               bytes[0] = fl_group[17:10];
               bytes[1] = fl_group[9:2];
            end
            group_in = '0;
            count_in = 2'd0;
         end
      end
      if (end_of_message) begin
         group_in  = '0;
         count_in  = 2'd0;
         halted_in = 1'b0;
      end
   end

   always_comb begin
      result.data       = bytes;
      result.done       = end_of_message;
      result.byte_valid = (n != 2'd0);
      result.count      = (end_of_message && n == 2'd0) ? 2'd1 : n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff  <= '0;
         count_ff  <= 2'd0;
         halted_ff <= 1'b0;
      end else if (accept) begin
         group_ff  <= group_in;
         count_ff  <= count_in;
         halted_ff <= halted_in;
      end
   end

`ifndef SYNTH
   a_halt_empty: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> count_ff == 2'd0)
      else $error("halted with pending symbols");

   a_eom_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_message) |=> (count_ff == 2'd0 && !halted_ff && group_ff == '0))
      else $error("state not cleared after end of message");
`endif

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   localparam logic [7:0] CHAR_CR      = 8'h0d;
   localparam logic [7:0] CHAR_LF      = 8'h0a;
   localparam logic [7:0] CHAR_PAD     = "=";
   localparam logic [7:0] CHAR_PLUS    = "+";
   localparam logic [7:0] CHAR_SLASH   = "/";
   localparam logic [7:0] CHAR_UPPER_A = "A";
   localparam logic [7:0] CHAR_UPPER_Z = "Z";
   localparam logic [7:0] CHAR_LOWER_A = "a";
   localparam logic [7:0] CHAR_LOWER_Z = "z";
   localparam logic [7:0] CHAR_DIGIT_0 = "0";
   localparam logic [7:0] CHAR_DIGIT_9 = "9";
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_HIGH    = 8'hff;
   localparam logic [6:0] CODE_BREAK   = 7'd64;
   localparam logic [6:0] CODE_INVALID = 7'd65;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_REQUESTS = 70;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] symbol
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;   // [7:0] data_byte
   logic       rsp_tuser;   // [0] byte_valid
   logic       rsp_tlast;

   // decoder state as predicted
   logic [17:0] group_bits = '0;
   logic [1:0]  group_count = '0;
   logic        halted = 1'b0;

   b64d_pkg::b64d_entry_type pending_bytes[$];
   b64d_pkg::b64d_entry_type step_bytes[$];
   int decoded_requests = 0;
   int mismatches = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit sender_idle = 1'b0;
   bit receiver_idle = 1'b0;

   base64_stream_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return 7'(c - CHAR_UPPER_A);
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return 7'(c - CHAR_LOWER_A + 8'd26);
      if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) return 7'(c - CHAR_DIGIT_0 + 8'd52);
      if (c == CHAR_PLUS) return 7'd62;
      if (c == CHAR_SLASH) return 7'd63;
      if (c == CHAR_CR || c == CHAR_LF) return CODE_BREAK;
      return CODE_INVALID;
   endfunction

   function automatic logic [7:0] alphabet_char(input logic [5:0] v);
      if (v < 6'd26) return CHAR_UPPER_A + 8'(v);
      if (v < 6'd52) return CHAR_LOWER_A + 8'(v - 6'd26);
      if (v < 6'd62) return CHAR_DIGIT_0 + 8'(v - 6'd52);
      if (v == 6'd62) return CHAR_PLUS;
      return CHAR_SLASH;
   endfunction

   function void push_byte(input logic [7:0] b);
      step_bytes.push_back('{data_byte: b, byte_valid: 1'b1, message_done: 1'b0});
   endfunction

   function void flush_group();
      if (group_count == 2'd2) begin
         push_byte(group_bits[11:4]);
      end else if (group_count == 2'd3) begin
         push_byte(group_bits[17:10]);
         push_byte(group_bits[9:2]);
      end
      group_bits = '0;
      group_count = '0;
   endfunction

   function void predict_decode(input logic [7:0] sym, input logic eom);
      logic [6:0] code;
      logic [23:0] word;
      b64d_pkg::b64d_entry_type last_entry;
      if (!halted || eom) decoded_requests++;
      if (!halted) begin
         code = sextet_of(sym);
         if (code < CODE_BREAK) begin
            if (group_count == 2'd3) begin
               word = {group_bits, code[5:0]};
               push_byte(word[23:16]);
               push_byte(word[15:8]);
               push_byte(word[7:0]);
               group_bits = '0;
               group_count = '0;
            end else begin
               group_bits = {group_bits[11:0], code[5:0]};
               group_count = group_count + 2'd1;
            end
         end else if (code == CODE_INVALID) begin
            flush_group();
            halted = 1'b1;
         end
         if (eom && !halted) flush_group();
      end
      if (eom) begin
         if (step_bytes.size() == 0) begin
            step_bytes.push_back('{data_byte: 8'h00, byte_valid: 1'b0, message_done: 1'b1});
         end else begin
            last_entry = step_bytes.pop_back();
            last_entry.message_done = 1'b1;
            step_bytes.push_back(last_entry);
         end
         group_bits = '0;
         group_count = '0;
         halted = 1'b0;
      end
      foreach (step_bytes[i]) pending_bytes.push_back(step_bytes[i]);
      step_bytes.delete();
   endfunction

   function void check_result(input logic [7:0] data, input logic valid, input logic done);
      b64d_pkg::b64d_entry_type want;
      if (pending_bytes.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: byte %02h valid %0b done %0b", data, valid, done);
         return;
      end
      want = pending_bytes.pop_front();
      if (want.data_byte !== data || want.byte_valid !== valid || want.message_done !== done) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected byte %02h valid %0b done %0b, %s %02h valid %0b done %0b",
                     want.data_byte, want.byte_valid, want.message_done, "got byte",
                     data, valid, done);
      end
   endfunction

   // result sink with random backpressure
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_request(input logic [7:0] sym, input logic eom);
      int gap;
      if (sender_idle && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= sym;
      req_tlast <= eom;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_decode(sym, eom);
   endtask

   task automatic send_text(input string s, input bit last_flag);
      for (int i = 0; i < s.len(); i++) send_request(s[i], last_flag && i == s.len() - 1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
   endtask

   task automatic send_message(input bit well_formed);
      logic [7:0] chars[$];
      int groups;
      int tail;
      int pads;
      int len;
      logic eom;
      if (well_formed) begin
         groups = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
         tail = $urandom_range(0, 3);
         for (int i = 0; i < groups * 4 + tail; i++) begin
            if ($urandom_range(0, 9) == 0) chars.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
            chars.push_back(alphabet_char(6'($urandom_range(0, 63))));
         end
         pads = (tail == 2) ? 2 : (tail == 3) ? 1 : 0;
         if ($urandom_range(0, 4) == 0) pads = $urandom_range(0, 2);
         repeat (pads) chars.push_back(CHAR_PAD);
         if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom_range(0, 255)));
      end else begin
         len = $urandom_range(1, 10);
         repeat (len)
            chars.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                 : alphabet_char(6'($urandom_range(0, 63))));
      end
      if (chars.size() == 0) chars.push_back(CHAR_LF);
      foreach (chars[i]) begin
         eom = (i == chars.size() - 1) || (!well_formed && $urandom_range(0, 7) == 0);
         send_request(chars[i], eom);
      end
   endtask

   task automatic test_full_groups();
      send_text("////", 1'b0);
      send_text("AAAA", 1'b0);
      send_text("+09z", 1'b1);
   endtask

   task automatic test_endings();
      send_text("aZ==", 1'b1);
      send_text("QU", 1'b0);
      send_request(CHAR_LF, 1'b0);
      send_text("J", 1'b1);
      send_text("Q", 1'b1);
      send_request(CHAR_CR, 1'b1);
      send_text("a", 1'b0);
      send_request(CHAR_HIGH, 1'b0);
      send_text("d", 1'b1);
      send_text("abc", 1'b0);
      send_request(CHAR_NUL, 1'b1);
   endtask

   task automatic test_random_stream();
      int target;
      target = decoded_requests + RANDOM_REQUESTS;
      while (decoded_requests < target) begin
         sender_idle = ($urandom_range(0, 3) != 0);
         receiver_idle = ($urandom_range(0, 3) != 0);
         send_message($urandom_range(0, 4) != 0);
      end
   endtask

   task automatic test_drain_pause();
      sender_idle = 1'b1;
      receiver_idle = 1'b1;
      send_message(1'b1);
      send_text("TWFu", 1'b0);
      wait_drained();
      send_text("TQ==", 1'b1);
      send_message(1'b1);
   endtask

   task automatic test_full_rate();
      int target;
      sender_idle = 1'b0;
      receiver_idle = 1'b0;
      target = decoded_requests + 40;
      while (decoded_requests < target) send_message($urandom_range(0, 5) != 0);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_full_groups();
      test_endings();
      test_random_stream();
      test_drain_pause();
      test_full_rate();

      wait_drained();
      repeat (16) @(posedge clock);
      if (mismatches == 0 && pending_bytes.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ base64_stream_decoder.f @@
rtl/core/b64d_pkg.sv
rtl/core/b64d_core.sv
rtl/core/base64_stream_decoder.sv
bench/testbench.sv
